@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CFPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define CFPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/cfpd_pkg.sv @@
// ----------------------------------------------------------------------------
// cfpd_pkg
// Shared types, constants and the CRC-16/Modbus byte update for the deframer.
// ----------------------------------------------------------------------------
package cfpd_pkg;

  // APB address width: three 32-bit registers at 0x0, 0x4, 0x8
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register reset values
  localparam logic [7:0] START_MARKER_RST = 8'hFA;
  localparam logic [7:0] OWN_ADDRESS_RST  = 8'h01;
  localparam logic [7:0] REQUEST_CODE_RST = 8'h04;

  // CRC-16/Modbus: init all ones, reflected poly, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Register word indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_START_MARKER = 2'd0,
    REG_OWN_ADDRESS  = 2'd1,
    REG_REQUEST_CODE = 2'd2
  } reg_idx_e;

  // Configuration seen by the parser
  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] own_address;
    logic [7:0] request_code;
  } cfg_t;

  // One byte through the reflected CRC, bit at a time
  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/cfpd_regs.sv @@
// ----------------------------------------------------------------------------
// cfpd_regs
// APB register file: start marker, own address and request code.
// ----------------------------------------------------------------------------
module cfpd_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cfpd_pkg::PADDR_W-1:0]  paddr,
  input  logic [cfpd_pkg::PDATA_W-1:0]  pwdata,
  output logic [cfpd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output cfpd_pkg::cfg_t                cfg_o
);
  import cfpd_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  // no wait states
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register write; unknown addresses are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= START_MARKER_RST;
      cfg_q.own_address  <= OWN_ADDRESS_RST;
      cfg_q.request_code <= REQUEST_CODE_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_START_MARKER: cfg_q.start_marker <= pwdata[7:0];
        REG_OWN_ADDRESS:  cfg_q.own_address  <= pwdata[7:0];
        REG_REQUEST_CODE: cfg_q.request_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_START_MARKER: prdata[7:0] = cfg_q.start_marker;
      REG_OWN_ADDRESS:  prdata[7:0] = cfg_q.own_address;
      REG_REQUEST_CODE: prdata[7:0] = cfg_q.request_code;
      default:          prdata      = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/crc_framed_packet_deframer_unit.sv @@
// Flow: a byte accepted into the input register is parsed once the output
// register can take its result, which is then registered onto the output ports.
// Throughput: one byte per cycle while results are taken; the bound is the
// single CRC-16 byte update in the parse stage.
// Reset (rst_ni low, async): hunting for a start byte, CRC at 0xFFFF, no beat
// held, registers back to 0xFA / 0x01 / 0x04.
// ----------------------------------------------------------------------------
// crc_framed_packet_deframer_unit
// Length-prefixed frame parser with CRC-16/Modbus check; emits payload bytes
// with their index and one end-of-frame summary per frame.
// ----------------------------------------------------------------------------
module crc_framed_packet_deframer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cfpd_pkg::PADDR_W-1:0]  paddr,
  input  logic [cfpd_pkg::PDATA_W-1:0]  pwdata,
  output logic [cfpd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // byte input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_kind_o,
  output logic [7:0]                    data_byte_o,
  output logic [7:0]                    payload_index_o,
  output logic [7:0]                    frame_addr_o,
  output logic [7:0]                    frame_cmd_o,
  output logic [7:0]                    frame_len_o,
  output logic                          crc_good_o,
  output logic                          request_for_me_o
);
  import cfpd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ADDR = 3'd1,
    PH_CMD  = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_CRCL = 3'd5,
    PH_CRCH = 3'd6
  } phase_e;

  cfg_t cfg;

  cfpd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       proc;

  // parse state
  phase_e      phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  crcl_q, crcl_d;

  // result of the current byte
  logic        res_vld;
  logic        res_kind;
  logic [7:0]  res_data, res_idx, res_addr, res_cmd, res_len;
  logic        res_good, res_mine;
  logic [15:0] crc_next;
  logic [7:0]  cnt_inc;

  // output register
  logic        out_vld_q;
  logic        kind_q, good_q, mine_q;
  logic [7:0]  data_q, idx_q, faddr_q, fcmd_q, flen_q;

  // a byte is parsed when the output register can take its result
  assign proc       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  assign crc_next = crc16_update(crc_q, in_byte_q);
  assign cnt_inc  = cnt_q + 8'd1;

  // byte parser
  always_comb begin
    phase_d  = phase_q;
    crc_d    = crc_q;
    addr_d   = addr_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    crcl_d   = crcl_q;
    res_vld  = 1'b0;
    res_kind = 1'b0;
    res_data = '0;
    res_idx  = '0;
    res_addr = '0;
    res_cmd  = '0;
    res_len  = '0;
    res_good = 1'b0;
    res_mine = 1'b0;
    unique case (phase_q)
      PH_ADDR: begin
        addr_d  = in_byte_q;
        crc_d   = crc_next;
        phase_d = PH_CMD;
      end
      PH_CMD: begin
        cmd_d   = in_byte_q;
        crc_d   = crc_next;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d   = in_byte_q;
        cnt_d   = '0;
        crc_d   = crc_next;
        phase_d = (in_byte_q != 8'd0) ? PH_DATA : PH_CRCL;
      end
      PH_DATA: begin
        res_vld  = 1'b1;
        res_data = in_byte_q;
        res_idx  = cnt_q;
        crc_d    = crc_next;
        cnt_d    = cnt_inc;
        if (cnt_inc == len_q) begin
          phase_d = PH_CRCL;
        end
      end
      PH_CRCL: begin
        crcl_d  = in_byte_q;
        phase_d = PH_CRCH;
      end
      PH_CRCH: begin
        res_vld  = 1'b1;
        res_kind = 1'b1;
        res_addr = addr_q;
        res_cmd  = cmd_q;
        res_len  = len_q;
        res_good = ({in_byte_q, crcl_q} == crc_q);
        res_mine = res_good && (addr_q == cfg.own_address)
                   && (cmd_q == cfg.request_code) && (len_q == 8'd0);
        crc_d    = CRC_INIT;
        phase_d  = PH_HUNT;
      end
      default: begin
        // hunting, and the unused phase code
        phase_d = PH_HUNT;
        if (in_byte_q == cfg.start_marker) begin
          crc_d   = crc16_update(CRC_INIT, in_byte_q);
          phase_d = PH_ADDR;
        end
      end
    endcase
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      crc_q   <= CRC_INIT;
      addr_q  <= '0;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      crcl_q  <= '0;
    end else if (proc) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      addr_q  <= addr_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      crcl_q  <= crcl_d;
    end
  end

  // output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc) begin
      out_vld_q <= res_vld;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (proc && res_vld) begin
      kind_q  <= res_kind;
      data_q  <= res_data;
      idx_q   <= res_idx;
      faddr_q <= res_addr;
      fcmd_q  <= res_cmd;
      flen_q  <= res_len;
      good_q  <= res_good;
      mine_q  <= res_mine;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_kind_o       = kind_q;
  assign data_byte_o      = data_q;
  assign payload_index_o  = idx_q;
  assign frame_addr_o     = faddr_q;
  assign frame_cmd_o      = fcmd_q;
  assign frame_len_o      = flen_q;
  assign crc_good_o       = good_q;
  assign request_for_me_o = mine_q;

endmodule

@@ rtl/cfpd_checker.sv @@
// ----------------------------------------------------------------------------
// cfpd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfpd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic pready,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic out_kind_o,
  input logic crc_good_o,
  input logic request_for_me_o
);

  // no result beat while reset is held
  `CFPD_ASSERT_ALWAYS(a_no_beat_in_reset, !rst_ni |-> !out_valid_o, "beat during reset")

  // config port never inserts wait states
  `CFPD_ASSERT(a_pready_high, pready, "pready low")

  // a request match needs a good CRC
  `CFPD_ASSERT(a_mine_needs_good, out_valid_o && request_for_me_o |-> crc_good_o, "match without good CRC")

  // payload beats carry no frame status
  `CFPD_ASSERT(a_payload_no_status, out_valid_o && !out_kind_o |-> !crc_good_o && !request_for_me_o, "status on payload beat")

  // a stalled beat holds its kind
  `CFPD_ASSERT(a_stall_holds, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_kind_o), "stalled beat dropped")

endmodule

bind crc_framed_packet_deframer_unit cfpd_checker u_cfpd_checker (.*);
